FILE: rtl/sfq_pkg.sv
// Shared command codes, cell operation codes and the cell control struct.
`default_nettype none

package sfq_pkg;

  // Command codes carried by in_cmd.
  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_POP   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_SORT  = 2'd3;

  // Width of the result's count field.
  localparam int OUT_CNT_W = 5;
  // Width of the value fields on the ports.
  localparam int PORT_VAL_W = 16;

  // Operation that every cell of the chain performs in the same cycle.
  localparam logic [1:0] CELL_HOLD  = 2'd0;
  localparam logic [1:0] CELL_PUSH  = 2'd1;
  localparam logic [1:0] CELL_SHIFT = 2'd2;
  localparam logic [1:0] CELL_SORT  = 2'd3;

  typedef struct packed {
    logic [1:0] op;     // one of the CELL_* codes
    logic       phase;  // sort pass parity: pairs start at even or odd cells
  } cell_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/sfq_cell.sv
// One storage cell of the queue chain with its compare-exchange logic.
`default_nettype none

module sfq_cell import sfq_pkg::*; #(
  parameter int DATA_WIDTH = 16,
  parameter int CW         = 5,
  parameter int INDEX      = 0
) (
  input  wire                          clk,
  input  cell_ctl_t                    ctl,
  input  wire logic [CW-1:0]           count,
  input  wire logic signed [DATA_WIDTH-1:0] push_val,
  input  wire logic signed [DATA_WIDTH-1:0] left_val,
  input  wire logic signed [DATA_WIDTH-1:0] right_val,
  output logic signed [DATA_WIDTH-1:0] val
);

  localparam logic [CW-1:0] IDX     = CW'(INDEX);
  localparam logic [CW:0]   IDX_P1  = (CW+1)'(INDEX + 1);
  localparam logic          IDX_ODD = 1'(INDEX % 2);

  logic signed [DATA_WIDTH-1:0] val_r;
  logic signed [DATA_WIDTH-1:0] val_nxt;
  logic                         pair_left;
  logic                         pair_right;

  // Upper member of a pair: parity matches the pass, right neighbor occupied.
  // Lower member: parity differs, the cell is occupied and is not cell 0.
  assign pair_left  = (IDX_ODD == ctl.phase) && (IDX_P1 < {1'b0, count});
  assign pair_right = (IDX_ODD != ctl.phase) && (INDEX != 0) && (IDX < count);

  always_comb begin
    val_nxt = val_r;
    case (ctl.op)
      CELL_PUSH: begin
        if (IDX == count) val_nxt = push_val;
      end
      CELL_SHIFT: begin
        val_nxt = right_val;
      end
      CELL_SORT: begin
        if (pair_left && (val_r < right_val)) val_nxt = right_val;
        else if (pair_right && (left_val < val_r)) val_nxt = left_val;
      end
      default: begin
        val_nxt = val_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

`default_nettype wire

FILE: rtl/sortable_fifo_queue.sv
// Top level of the sortable queue: command decode, fill count and result port.
`default_nettype none

// Bounded queue of DEPTH signed entries kept in a chain of cells, head in the
// first cell. A command beat is taken when start is high and busy is low.
// Push, pop and clear give their result beat on the out_ ports, marked by
// out_strobe, in the cycle after the command is taken, while the next
// command may already be taken. Sort runs an odd-even transposition sort
// through the chain, one compare-exchange pass per cycle, as many passes as
// there are stored entries; busy is high for those passes and the result
// beat follows the last one. A sort of fewer than two entries behaves like
// push, pop and clear. The result beat lasts exactly one cycle and cannot be
// held off, so the receiver must take it when out_strobe is high. Entries
// above the fill count are never shown; a pop of an empty queue, and the
// head of an empty queue, report zero.
module sortable_fifo_queue import sfq_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 16
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  output logic               busy,
  input  wire  [1:0]         in_cmd,
  input  wire  signed [15:0] in_item_value,
  output logic               out_strobe,
  output logic signed [15:0] out_popped_value,
  output logic signed [15:0] out_head_value,
  output logic [4:0]         out_entry_count,
  output logic               out_was_empty,
  output logic               out_overflow
);

  // Count width holds DEPTH itself.
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic signed [DATA_WIDTH-1:0] cell_val [DEPTH];
  logic signed [DATA_WIDTH-1:0] push_val;
  cell_ctl_t                    ctl;

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] sort_cnt_r, sort_cnt_nxt;
  logic          sort_active_r, sort_active_nxt;
  logic          phase_r, phase_nxt;
  logic          done_r, done_nxt;
  logic signed [PORT_VAL_W-1:0] popped_r, popped_nxt;
  logic          was_empty_r, was_empty_nxt;
  logic          overflow_r, overflow_nxt;
  logic          accept;

  assign accept   = start && !sort_active_r;
  assign push_val = DATA_WIDTH'(in_item_value);

  // Decode the accepted command, or a sort pass, into one chain operation
  // and the next control state. Flags are cleared by all commands but their own.
  always_comb begin
    ctl.op          = CELL_HOLD;
    ctl.phase       = phase_r;
    count_nxt       = count_r;
    sort_cnt_nxt    = sort_cnt_r;
    sort_active_nxt = sort_active_r;
    phase_nxt       = phase_r;
    done_nxt        = 1'b0;
    popped_nxt      = popped_r;
    was_empty_nxt   = was_empty_r;
    overflow_nxt    = overflow_r;

    if (sort_active_r) begin
      // One odd-even pass per cycle; the last pass releases the result.
      ctl.op       = CELL_SORT;
      phase_nxt    = !phase_r;
      sort_cnt_nxt = sort_cnt_r - CW'(1);
      if (sort_cnt_r == CW'(1)) begin
        sort_active_nxt = 1'b0;
        done_nxt        = 1'b1;
      end
    end else if (accept) begin
      popped_nxt    = '0;
      was_empty_nxt = 1'b0;
      overflow_nxt  = 1'b0;
      case (in_cmd)
        CMD_PUSH: begin
          done_nxt = 1'b1;
          if (count_r < DEPTH_C) begin
            ctl.op    = CELL_PUSH;
            count_nxt = count_r + CW'(1);
          end else begin
            overflow_nxt = 1'b1;
          end
        end
        CMD_POP: begin
          done_nxt = 1'b1;
          if (count_r != '0) begin
            ctl.op     = CELL_SHIFT;
            popped_nxt = PORT_VAL_W'(cell_val[0]);
            count_nxt  = count_r - CW'(1);
          end else begin
            was_empty_nxt = 1'b1;
          end
        end
        CMD_CLEAR: begin
          done_nxt  = 1'b1;
          count_nxt = '0;
        end
        CMD_SORT: begin
          // Fewer than two entries are already in order.
          if (count_r > CW'(1)) begin
            sort_active_nxt = 1'b1;
            sort_cnt_nxt    = count_r;
            phase_nxt       = 1'b0;
          end else begin
            done_nxt = 1'b1;
          end
        end
        default: begin
          done_nxt = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r       <= '0;
      sort_cnt_r    <= '0;
      sort_active_r <= 1'b0;
      phase_r       <= 1'b0;
      done_r        <= 1'b0;
    end else begin
      count_r       <= count_nxt;
      sort_cnt_r    <= sort_cnt_nxt;
      sort_active_r <= sort_active_nxt;
      phase_r       <= phase_nxt;
      done_r        <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    popped_r    <= popped_nxt;
    was_empty_r <= was_empty_nxt;
    overflow_r  <= overflow_nxt;
  end

  // The chain: each cell sees both neighbors. The head has no left partner
  // and the tail has no right partner, so those inputs never matter.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [DATA_WIDTH-1:0] left_val;
    logic signed [DATA_WIDTH-1:0] right_val;

    if (g == 0) begin : g_head
      assign left_val = cell_val[0];
    end else begin : g_mid_l
      assign left_val = cell_val[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign right_val = cell_val[g];
    end else begin : g_mid_r
      assign right_val = cell_val[g+1];
    end

    sfq_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CW         (CW),
      .INDEX      (g)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .count     (count_r),
      .push_val  (push_val),
      .left_val  (left_val),
      .right_val (right_val),
      .val       (cell_val[g])
    );
  end

  // The result beat reads the state left by the finished command.
  assign busy             = sort_active_r;
  assign out_strobe       = done_r;
  assign out_popped_value = popped_r;
  assign out_head_value   = (count_r != '0) ? PORT_VAL_W'(cell_val[0]) : '0;
  assign out_entry_count  = OUT_CNT_W'(count_r);
  assign out_was_empty    = was_empty_r;
  assign out_overflow     = overflow_r;

  // The fill count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("fill count above capacity");

  // A result beat never appears while a sort is still running.
  a_no_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !(busy && out_strobe))
    else $error("result beat during sort");

  // Push, pop or clear gives its result in the next cycle.
  a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_cmd != CMD_SORT)) |=> out_strobe)
    else $error("missing result after one-cycle command");

  // A sort of two or more entries makes the block busy and leaves the count.
  a_sort_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_cmd == CMD_SORT) && (count_r > CW'(1)))
    |=> (busy && $stable(count_r)))
    else $error("sort did not start");

endmodule

`default_nettype wire
